// ----- hdl/lfst_pkg.sv -----
// ----------------------------------------------------------------------------
// lfst_pkg
// Types and constants for the lowest free slot handle table.
// ----------------------------------------------------------------------------
package lfst_pkg;

  localparam int CAPACITY   = 256;
  localparam int VALUE_BITS = 32;

  localparam int MODE_W  = 3;
  localparam int KEY_W   = 8;
  localparam int VALUE_W = 32;
  localparam int SLOT_W  = 8;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int MARK_W = IDX_W + 1;
  localparam int CMP_W  = (MARK_W > KEY_W) ? MARK_W : KEY_W;

  // The free-slot and trim scans look at one chunk of the occupancy bitmap per cycle.
  localparam int CHUNK   = (CAPACITY >= 16) ? 16 : CAPACITY;
  localparam int CB      = $clog2(CHUNK);
  localparam int NCHUNK  = CAPACITY / CHUNK;
  localparam int CW      = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

  localparam logic [MODE_W-1:0] MODE_GET    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TEST   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ALLOC  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SET    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic               present;
    logic [SLOT_W-1:0]  slot;
    logic               full_res;
  } res_t;

endpackage

// ----- hdl/lfst_ram.sv -----
// ----------------------------------------------------------------------------
// lfst_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module lfst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ----- hdl/lowest_free_slot_table_core.sv -----
// ----------------------------------------------------------------------------
// lowest_free_slot_table_core
// Handle table with a high-water mark, lowest-free-slot alloc and mark trim.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low; its result is shown on
// res_o for exactly one cycle with res_valid_o high, and cannot be held off.
// Test, set and unused modes answer in the cycle after the beat, get from
// the read state after its RAM read. Alloc runs the scan state; remove runs
// the read state and, for a live key, the scan state, which walks 1 to
// CAPACITY/16 16-bit chunks of the occupancy bitmap with the shared chunk
// scanner: up from slot 0 for the lowest free slot, down from the top for
// the trimmed mark. Reset clears the bitmap, so the table is usable at once.
module lowest_free_slot_table_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  lfst_pkg::req_t req_i,
  output lfst_pkg::res_t res_o,
  output logic          res_valid_o
);
  import lfst_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [MODE_W-1:0]     mode_q, mode_d;
  logic [IDX_W-1:0]      key_q, key_d;
  logic                  keyok_q, keyok_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [CAPACITY-1:0]   nz_q, nz_d;
  logic [MARK_W-1:0]     mark_q, mark_d;
  logic [CW-1:0]         chunk_q, chunk_d;
  res_t                  res_q, res_d;
  logic                  res_valid_q, res_valid_d;

  logic                  accept;
  logic [63:0]           val_in64;
  logic [VALUE_BITS-1:0] val_in;
  logic                  key_ok_in;
  logic [IDX_W-1:0]      key_idx_in;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_addr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic [VALUE_BITS-1:0] ram_rdata;
  logic [63:0]           rd64;
  logic [63:0]           held64;

  logic                  scan_up;
  logic [CHUNK-1:0]      scan_vec;
  logic                  scan_hit;
  logic [CB-1:0]         scan_bit;
  logic [IDX_W-1:0]      scan_pos;

  assign accept     = start && !busy;
  assign val_in64   = 64'(req_i.value);
  assign val_in     = val_in64[VALUE_BITS-1:0];
  assign key_ok_in  = CMP_W'(req_i.key) < CMP_W'(CAPACITY);
  assign key_idx_in = IDX_W'(req_i.key);
  assign rd64       = 64'(ram_rdata);
  assign held64     = 64'(val_q);

  // Shared chunk scanner: lowest free bit going up, highest used bit going down.
  assign scan_up  = (mode_q == MODE_ALLOC);
  assign scan_vec = scan_up ? ~nz_q[{chunk_q, CB'(0)} +: CHUNK]
                            :  nz_q[{chunk_q, CB'(0)} +: CHUNK];
  assign scan_hit = |scan_vec;

  always_comb begin
    scan_bit = '0;
    if (scan_up) begin
      for (int i = CHUNK - 1; i >= 0; i--) begin
        if (scan_vec[i]) scan_bit = CB'(i);
      end
    end else begin
      for (int i = 0; i < CHUNK; i++) begin
        if (scan_vec[i]) scan_bit = CB'(i);
      end
    end
  end

  assign scan_pos = IDX_W'({chunk_q, scan_bit});

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = key_idx_in;
    ram_wdata = val_in;
    if (accept && req_i.mode == MODE_SET && key_ok_in) begin
      ram_we = 1'b1;
    end else if (state_q == ST_SCAN && scan_up && scan_hit) begin
      ram_we    = 1'b1;
      ram_addr  = scan_pos;
      ram_wdata = val_q;
    end
  end

  lfst_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    key_d       = key_q;
    keyok_d     = keyok_q;
    val_d       = val_q;
    nz_d        = nz_q;
    mark_d      = mark_q;
    chunk_d     = chunk_q;
    res_d       = '0;
    res_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          mode_d  = req_i.mode;
          key_d   = key_idx_in;
          keyok_d = key_ok_in;
          val_d   = val_in;
          unique case (req_i.mode)
            MODE_GET, MODE_REMOVE: begin
              state_d = ST_READ;
            end
            MODE_TEST: begin
              res_d.present = key_ok_in && nz_q[key_idx_in];
              res_valid_d   = 1'b1;
            end
            MODE_ALLOC: begin
              chunk_d = '0;
              state_d = ST_SCAN;
            end
            MODE_SET: begin
              if (key_ok_in) begin
                nz_d[key_idx_in] = |val_in;
                if (MARK_W'(key_idx_in) >= mark_q) begin
                  mark_d = MARK_W'(key_idx_in) + MARK_W'(1);
                end
              end
              res_valid_d = 1'b1;
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end

      ST_READ: begin
        if (mode_q == MODE_GET) begin
          if (keyok_q && nz_q[key_q]) res_d.read_value = rd64[VALUE_W-1:0];
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else if (keyok_q && nz_q[key_q]) begin
          // Hold the removed entry, clear it, then trim the mark.
          val_d        = ram_rdata;
          nz_d[key_q]  = 1'b0;
          chunk_d      = CW'(NCHUNK - 1);
          state_d      = ST_SCAN;
        end else begin
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      ST_SCAN: begin
        if (scan_up) begin
          if (scan_hit) begin
            nz_d[scan_pos] = |val_q;
            if (MARK_W'(scan_pos) == mark_q) mark_d = mark_q + MARK_W'(1);
            res_d.slot  = SLOT_W'(scan_pos);
            res_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end else if (chunk_q == CW'(NCHUNK - 1)) begin
            res_d.full_res = 1'b1;
            res_valid_d    = 1'b1;
            state_d        = ST_IDLE;
          end else begin
            chunk_d = chunk_q + CW'(1);
          end
        end else begin
          if (scan_hit || chunk_q == '0) begin
            mark_d           = scan_hit ? MARK_W'(scan_pos) + MARK_W'(1) : '0;
            res_d.read_value = held64[VALUE_W-1:0];
            res_valid_d      = 1'b1;
            state_d          = ST_IDLE;
          end else begin
            chunk_d = chunk_q - CW'(1);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      nz_q        <= '0;
      mark_q      <= '0;
      chunk_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nz_q        <= nz_d;
      mark_q      <= mark_d;
      chunk_q     <= chunk_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    key_q   <= key_d;
    keyok_q <= keyok_d;
    val_q   <= val_d;
    res_q   <= res_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  a_mark_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mark_q <= MARK_W'(CAPACITY))
    else $error("high-water mark beyond capacity");

  a_test_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.mode == MODE_TEST) |=> res_valid_o)
    else $error("test beat did not answer in one cycle");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result strobe while still busy");

  a_no_write_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> !ram_we)
    else $error("entry write during read cycle");

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lowest_free_slot_table_core. A directed table walks
// the empty table, the edges of alloc, set and remove, and the unused modes;
// random traffic then grows, fills, drains and churns the table. Each beat is
// fed to an in-bench table predictor at the edge that accepts it, and every
// result strobe is compared field by field with the oldest pending answer.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfst_pkg::*;

  typedef struct {
    req_t rq;
    bit   known;
    res_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  res_t res_o;
  logic res_valid_o;

  // predictor state
  logic [VALUE_W-1:0] table_slots [CAPACITY];
  int                 table_mark;

  res_t     pending_answers [$];
  dir_row_t dir_rows [$];
  res_t     last_answer;
  res_t     head;
  int       idle_pct;
  int       mismatch_count;

  lowest_free_slot_table_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

  always #6 clk_i = ~clk_i;

  // Advance the table by one request and return its answer.
  function automatic res_t apply_request(req_t rq);
    res_t ans;
    bit   placed;
    ans = '0;
    case (rq.mode)
      MODE_GET: begin
        if (rq.key < table_mark) ans.read_value = table_slots[rq.key];
      end
      MODE_TEST: begin
        ans.present = (rq.key < table_mark) && (table_slots[rq.key] != '0);
      end
      MODE_ALLOC: begin
        placed = 1'b0;
        for (int i = 0; i < table_mark; i++) begin
          if (table_slots[i] == '0) begin
            table_slots[i] = rq.value;
            ans.slot = SLOT_W'(i);
            placed = 1'b1;
            break;
          end
        end
        if (!placed) begin
          if (table_mark >= CAPACITY) begin
            ans.full_res = 1'b1;
          end else begin
            table_slots[table_mark] = rq.value;
            ans.slot = SLOT_W'(table_mark);
            table_mark++;
          end
        end
      end
      MODE_SET: begin
        if (rq.key < CAPACITY) begin
          while (table_mark <= rq.key) begin
            table_slots[table_mark] = '0;
            table_mark++;
          end
          table_slots[rq.key] = rq.value;
        end
      end
      MODE_REMOVE: begin
        if (rq.key < table_mark && table_slots[rq.key] != '0) begin
          ans.read_value = table_slots[rq.key];
          table_slots[rq.key] = '0;
          while (table_mark > 0 && table_slots[table_mark-1] == '0) table_mark--;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  function automatic void add_row(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                                  logic [VALUE_W-1:0] value);
    dir_row_t row;
    row.rq = '{mode: mode, key: key, value: value};
    row.known = 1'b0;
    row.want = '0;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_known(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                                    logic [VALUE_W-1:0] value, logic [VALUE_W-1:0] rd,
                                    logic pres, logic [SLOT_W-1:0] slot);
    dir_row_t row;
    row.rq = '{mode: mode, key: key, value: value};
    row.known = 1'b1;
    row.want = '{read_value: rd, present: pres, slot: slot, full_res: 1'b0};
    dir_rows.push_back(row);
  endfunction

  function automatic req_t make_request(bit drain);
    req_t rq;
    int   w;
    int   near;
    w = $urandom_range(0, 99);
    near = (table_mark + 3 > CAPACITY - 1) ? CAPACITY - 1 : table_mark + 3;
    // keep most keys around the mark so they land on live entries
    if ($urandom_range(0, 9) < 7) rq.key = KEY_W'($urandom_range(0, near));
    else rq.key = KEY_W'($urandom_range(0, CAPACITY - 1));
    case ($urandom_range(0, 19))
      0: rq.value = '0;
      1: rq.value = '1;
      default: rq.value = $urandom();
    endcase
    if (w < (drain ? 50 : 25)) rq.mode = MODE_REMOVE;
    else if (w < (drain ? 60 : 55)) rq.mode = MODE_ALLOC;
    else if (w < 70) rq.mode = MODE_GET;
    else if (w < 84) rq.mode = MODE_TEST;
    else if (w < 95) rq.mode = MODE_SET;
    else rq.mode = MODE_REMOVE + MODE_W'($urandom_range(1, 3));
    return rq;
  endfunction

  // Drive one beat, hold it until taken, then record its answer.
  task automatic issue(req_t rq, bit known, res_t want);
    if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= rq;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    last_answer = apply_request(rq);
    pending_answers.push_back(known ? want : last_answer);
  endtask

  task automatic run_mixed(int count, bit drain, bit vary_idle);
    for (int n = 0; n < count; n++) begin
      if (vary_idle && n % 20 == 0) idle_pct = $urandom_range(0, 2) * 30;
      issue(make_request(drain), 1'b0, '0);
    end
  endtask

  function automatic void check_field(string name, logic [VALUE_W-1:0] want,
                                      logic [VALUE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %p", $time, res_o);
        mismatch_count++;
      end else begin
        head = pending_answers.pop_front();
        check_field("read_value", head.read_value, res_o.read_value);
        check_field("present", head.present, res_o.present);
        check_field("slot", head.slot, res_o.slot);
        check_field("full_res", head.full_res, res_o.full_res);
      end
    end
  end

  initial begin
    req_t rq;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    idle_pct = 30;
    mismatch_count = 0;
    foreach (table_slots[i]) table_slots[i] = '0;
    table_mark = 0;

    // empty table
    add_known(MODE_GET,    8'd0,   32'h0,        32'h0,        1'b0, 8'd0);
    add_known(MODE_TEST,   8'd0,   32'h0,        32'h0,        1'b0, 8'd0);
    add_known(MODE_REMOVE, 8'd0,   32'h0,        32'h0,        1'b0, 8'd0);
    // append at the mark
    add_known(MODE_ALLOC,  8'd0,   32'hFFFFFFFF, 32'h0,        1'b0, 8'd0);
    add_known(MODE_ALLOC,  8'd255, 32'h00000001, 32'h0,        1'b0, 8'd1);
    add_known(MODE_GET,    8'd0,   32'h0,        32'hFFFFFFFF, 1'b0, 8'd0);
    add_known(MODE_TEST,   8'd1,   32'h0,        32'h0,        1'b1, 8'd0);
    add_known(MODE_GET,    8'd2,   32'h0,        32'h0,        1'b0, 8'd0);
    // zero value still takes a slot and leaves a hole
    add_known(MODE_ALLOC,  8'd0,   32'h0,        32'h0,        1'b0, 8'd2);
    add_known(MODE_TEST,   8'd2,   32'h0,        32'h0,        1'b0, 8'd0);
    add_known(MODE_ALLOC,  8'd0,   32'h00000005, 32'h0,        1'b0, 8'd2);
    // set at the top key raises the mark to capacity
    add_known(MODE_SET,    8'd255, 32'hA5A5A5A5, 32'h0,        1'b0, 8'd0);
    add_known(MODE_GET,    8'd255, 32'h0,        32'hA5A5A5A5, 1'b0, 8'd0);
    add_row  (MODE_GET,    8'd254, 32'h0);
    add_known(MODE_SET,    8'd200, 32'h0,        32'h0,        1'b0, 8'd0);
    // remove at the top trims the mark down past the empty run
    add_known(MODE_REMOVE, 8'd255, 32'h0,        32'hA5A5A5A5, 1'b0, 8'd0);
    add_row  (MODE_GET,    8'd200, 32'h0);
    add_row  (MODE_SET,    8'd10,  32'h0);
    add_row  (MODE_REMOVE, 8'd10,  32'h0);
    add_row  (MODE_ALLOC,  8'd0,   32'h00000007);
    add_known(MODE_REMOVE + 3'd1, 8'd255, 32'hFFFFFFFF, 32'h0, 1'b0, 8'd0);
    add_known(MODE_REMOVE + 3'd2, 8'd255, 32'hFFFFFFFF, 32'h0, 1'b0, 8'd0);
    add_known(MODE_REMOVE + 3'd3, 8'd255, 32'hFFFFFFFF, 32'h0, 1'b0, 8'd0);
    add_row  (MODE_REMOVE, 8'd3,   32'h0);
    add_row  (MODE_REMOVE, 8'd2,   32'h0);
    add_row  (MODE_TEST,   8'd0,   32'h0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) issue(dir_rows[i].rq, dir_rows[i].known, dir_rows[i].want);

    run_mixed(100, 1'b0, 1'b1);

    // fill to capacity, then knock on the full table
    idle_pct = 25;
    rq = '{mode: MODE_SET, key: 8'd255, value: $urandom() | 32'h1};
    issue(rq, 1'b0, '0);
    do begin
      rq = '{mode: MODE_ALLOC, key: KEY_W'($urandom()), value: $urandom() | 32'h1};
      issue(rq, 1'b0, '0);
    end while (!last_answer.full_res);
    repeat (2) issue(rq, 1'b0, '0);

    run_mixed(80, 1'b1, 1'b1);

    idle_pct = 0;
    run_mixed(40, 1'b0, 1'b0);
    start <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- lowest_free_slot_table_core.f -----
hdl/lfst_pkg.sv
hdl/lfst_ram.sv
hdl/lowest_free_slot_table_core.sv
bench/tb.sv
